// ===== rtl/fiducial_box_circle_veto_macros.svh =====
// Assertion macros for the fiducial box/circle veto block.
// Used by fiducial_box_circle_veto.sv; expects clk and rst_n in scope.
`ifndef FIDUCIAL_BOX_CIRCLE_VETO_MACROS_SVH
`define FIDUCIAL_BOX_CIRCLE_VETO_MACROS_SVH
`ifndef SYNTHESIS
`define FBCV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbcv assertion failed");
`define FBCV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbcv assertion failed");
`else
`define FBCV_ASSERT_IMP(lbl, ante, cons)
`define FBCV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/fbcv_pkg.sv =====
// Shared types and constants for the fiducial box/circle veto block.
// No dependencies.
`default_nettype none
package fbcv_pkg;

    localparam int COORD_W = 16;
    localparam int HW_W    = 15;
    localparam int RAD_W   = 15;

    // function codes of an input item
    localparam logic [1:0] FUNC_TEST  = 2'd0;
    localparam logic [1:0] FUNC_DEAD  = 2'd1;
    localparam logic [1:0] FUNC_TRIG  = 2'd2;
    localparam logic [1:0] FUNC_CIRC  = 2'd3;

    // reject reasons
    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_DEAD = 2'd1;
    localparam logic [1:0] REASON_TRIG = 2'd2;
    localparam logic [1:0] REASON_CIRC = 2'd3;

    // register indexes
    localparam logic [2:0] REG_DEAD_HW   = 3'd0;
    localparam logic [2:0] REG_TRIG_HW   = 3'd1;
    localparam logic [2:0] REG_DEAD_CNT  = 3'd2;
    localparam logic [2:0] REG_TRIG_CNT  = 3'd3;
    localparam logic [2:0] REG_CIRC_CNT  = 3'd4;

    // standard circle: centre x = -2.025 cm, radius 12 cm
    localparam int CIRC0_X_MILLI = 2025;
    localparam int CIRC0_R_CM    = 12;
    localparam int RAD_MAX       = 32767;

    typedef enum logic [1:0] {
        OP_NONE      = 2'd0,
        OP_SQ_DX     = 2'd1,
        OP_SQ_DY_ACC = 2'd2,
        OP_SQ_R_ADD  = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t         op;
        logic [HW_W-1:0] hw;
    } alu_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/fbcv_box_ram.sv =====
// Box centre store: one write port, one registered read port.
// Depends on nothing but its parameter.
`default_nettype none
module fbcv_box_ram #(
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [31:0]           wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [31:0]           rdata
);
    logic [31:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/fbcv_alu.sv =====
// Shared compare and square-accumulate unit.
// Uses fbcv_pkg for the operation codes and control struct.
`default_nettype none
module fbcv_alu (
    input  wire logic                                 clk,
    input  wire fbcv_pkg::alu_ctl_t                   ctl,
    input  wire logic signed [fbcv_pkg::COORD_W-1:0]  pt_x,
    input  wire logic signed [fbcv_pkg::COORD_W-1:0]  pt_y,
    input  wire logic signed [fbcv_pkg::COORD_W-1:0]  ctr_x,
    input  wire logic signed [fbcv_pkg::COORD_W-1:0]  ctr_y,
    input  wire logic [fbcv_pkg::RAD_W-1:0]           radius,
    output logic                                      box_hit,
    output logic                                      circ_hit
);
    logic [16:0] dx, dy, ndx, ndy;
    logic [15:0] adx, ady, mul_a;
    logic [31:0] sq;
    logic [31:0] prod_reg;
    logic [32:0] acc_reg;

    always_comb
    begin
        dx  = {pt_x[15], pt_x} - {ctr_x[15], ctr_x};
        dy  = {pt_y[15], pt_y} - {ctr_y[15], ctr_y};
        ndx = 17'd0 - dx;
        ndy = 17'd0 - dy;
        adx = dx[16] ? ndx[15:0] : dx[15:0];
        ady = dy[16] ? ndy[15:0] : dy[15:0];
        box_hit = (adx <= {1'b0, ctl.hw}) && (ady <= {1'b0, ctl.hw});
        case (ctl.op)
            fbcv_pkg::OP_SQ_DX:     mul_a = adx;
            fbcv_pkg::OP_SQ_DY_ACC: mul_a = ady;
            fbcv_pkg::OP_SQ_R_ADD:  mul_a = {1'b0, radius};
            default:                mul_a = adx;
        endcase
        sq       = mul_a * mul_a;
        circ_hit = acc_reg <= {1'b0, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            fbcv_pkg::OP_SQ_DX:
            begin
                prod_reg <= sq;
            end
            fbcv_pkg::OP_SQ_DY_ACC:
            begin
                acc_reg  <= {1'b0, prod_reg};
                prod_reg <= sq;
            end
            fbcv_pkg::OP_SQ_R_ADD:
            begin
                acc_reg  <= acc_reg + {1'b0, prod_reg};
                prod_reg <= sq;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/fiducial_box_circle_veto.sv =====
// Fiducial box/circle veto: an input item either loads a table entry or tests a
// point against the dead cell boxes, the trigger cell boxes and the veto circles.
// Config on an APB-style port. Entries walked through fbcv_alu, box entries one per cycle.
//
// Usage notes:
//   Input items on s_axis_*, func in tuser; results on m_axis_*, write flag in tuser.
//   Exactly one result item per input item, in order.
//   A write item passes to the finish state and then into the output register.
//   A test item walks the active dead boxes, then the active trigger boxes, then
//   the active circles; the walk stops at the first region that holds the point.
//   The time is set by the box stores, read one entry a cycle, and by the single
//   multiplier, used three times for each circle.
//   s_axis_tready is high only while no item is in progress; one item at a time.
//   The result waits in an output register; a stalled receiver holds the block
//   once the next item's result is ready, and the input is taken again after.
//   Reset clears control state and registers, and reloads the standard circle
//   in entry 0. Box stores hold no reset value: write entries before use.
//   Registers may be written only while the block is idle.
`default_nettype none
`include "fiducial_box_circle_veto_macros.svh"
module fiducial_box_circle_veto #(
    parameter int BOX_ENTRIES      = 32,
    parameter int TRIG_BOX_ENTRIES = 32,
    parameter int CIRCLE_ENTRIES   = 4,
    parameter int FRAC_BITS        = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_index[4:0], pos_x[20:5], pos_y[36:21], circle_radius[51:37], zero pad
    input  wire logic [55:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accepted[0], reject_reason[2:1], zero pad
    output logic [7:0]       m_axis_tdata,
    // write_ack[0]
    output logic [0:0]       m_axis_tuser
);
    localparam int MAXD  = (BOX_ENTRIES > TRIG_BOX_ENTRIES) ? BOX_ENTRIES : TRIG_BOX_ENTRIES;
    localparam int CNTW  = $clog2(MAXD + 1);
    localparam int DAW   = (BOX_ENTRIES > 1) ? $clog2(BOX_ENTRIES) : 1;
    localparam int TAW   = (TRIG_BOX_ENTRIES > 1) ? $clog2(TRIG_BOX_ENTRIES) : 1;
    localparam int CCW   = $clog2(CIRCLE_ENTRIES + 1);
    localparam int CIW   = (CIRCLE_ENTRIES > 1) ? $clog2(CIRCLE_ENTRIES) : 1;
    localparam int R_FULL  = fbcv_pkg::CIRC0_R_CM << FRAC_BITS;
    localparam int R_RESET = (R_FULL > fbcv_pkg::RAD_MAX) ? fbcv_pkg::RAD_MAX : R_FULL;
    localparam int CX_MAG  = (fbcv_pkg::CIRC0_X_MILLI * (1 << FRAC_BITS) + 500) / 1000;
    localparam logic [15:0] CX_RESET = 16'(0 - CX_MAG);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BOX  = 4'b0010,
        ST_CIRC = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // input unpack
    logic [1:0]         in_func;
    logic [4:0]         in_idx;
    logic signed [15:0] in_x, in_y;
    logic [14:0]        in_rad;
    logic               in_acc;

    assign in_func = s_axis_tuser;
    assign in_idx  = s_axis_tdata[4:0];
    assign in_x    = s_axis_tdata[20:5];
    assign in_y    = s_axis_tdata[36:21];
    assign in_rad  = s_axis_tdata[51:37];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // config registers
    logic [14:0] dead_hw_reg, trig_hw_reg;
    logic [5:0]  dead_cnt_reg, trig_cnt_reg;
    logic [2:0]  circ_cnt_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_hw_reg  <= '0;
            trig_hw_reg  <= '0;
            dead_cnt_reg <= '0;
            trig_cnt_reg <= '0;
            circ_cnt_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                fbcv_pkg::REG_DEAD_HW:  dead_hw_reg  <= pwdata[14:0];
                fbcv_pkg::REG_TRIG_HW:  trig_hw_reg  <= pwdata[14:0];
                fbcv_pkg::REG_DEAD_CNT: dead_cnt_reg <= pwdata[5:0];
                fbcv_pkg::REG_TRIG_CNT: trig_cnt_reg <= pwdata[5:0];
                fbcv_pkg::REG_CIRC_CNT: circ_cnt_reg <= pwdata[2:0];
                default:                dead_hw_reg  <= dead_hw_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            fbcv_pkg::REG_DEAD_HW:  prdata = 32'(dead_hw_reg);
            fbcv_pkg::REG_TRIG_HW:  prdata = 32'(trig_hw_reg);
            fbcv_pkg::REG_DEAD_CNT: prdata = 32'(dead_cnt_reg);
            fbcv_pkg::REG_TRIG_CNT: prdata = 32'(trig_cnt_reg);
            fbcv_pkg::REG_CIRC_CNT: prdata = 32'(circ_cnt_reg);
            default:                prdata = '0;
        endcase
    end

    // active counts, saturated at table depth
    logic [CNTW-1:0] n_dead, n_trig, n_cur;
    logic [CCW-1:0]  n_circ;

    assign n_dead = (32'(dead_cnt_reg) > BOX_ENTRIES) ? CNTW'(BOX_ENTRIES) : CNTW'(dead_cnt_reg);
    assign n_trig = (32'(trig_cnt_reg) > TRIG_BOX_ENTRIES) ?
                    CNTW'(TRIG_BOX_ENTRIES) : CNTW'(trig_cnt_reg);
    assign n_circ = (32'(circ_cnt_reg) > CIRCLE_ENTRIES) ?
                    CCW'(CIRCLE_ENTRIES) : CCW'(circ_cnt_reg);

    // sequencer state
    state_t             state_reg, state_next;
    logic               tbl_reg, tbl_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [CCW-1:0]     cidx_reg, cidx_next;
    logic [1:0]         cstep_reg, cstep_next;
    logic signed [15:0] px_reg, px_next, py_reg, py_next;
    logic [1:0]         reason_reg, reason_next;
    logic               wack_reg, wack_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_reason_reg;
    logic               out_wack_reg;
    logic               out_load;

    // circle store
    logic signed [15:0] circ_x_reg [CIRCLE_ENTRIES];
    logic signed [15:0] circ_y_reg [CIRCLE_ENTRIES];
    logic [14:0]        circ_r_reg [CIRCLE_ENTRIES];
    logic               circ_we;

    assign circ_we = in_acc && (in_func == fbcv_pkg::FUNC_CIRC) && (32'(in_idx) < CIRCLE_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CIRCLE_ENTRIES; i++)
            begin
                circ_x_reg[i] <= (i == 0) ? CX_RESET : 16'd0;
                circ_y_reg[i] <= '0;
                circ_r_reg[i] <= (i == 0) ? 15'(R_RESET) : 15'd0;
            end
        end
        else if (circ_we)
        begin
            circ_x_reg[CIW'(in_idx)] <= in_x;
            circ_y_reg[CIW'(in_idx)] <= in_y;
            circ_r_reg[CIW'(in_idx)] <= in_rad;
        end
    end

    // box stores
    logic        dead_we, trig_we;
    logic [31:0] dead_rdata, trig_rdata;

    assign dead_we = in_acc && (in_func == fbcv_pkg::FUNC_DEAD) && (32'(in_idx) < BOX_ENTRIES);
    assign trig_we = in_acc && (in_func == fbcv_pkg::FUNC_TRIG) &&
                     (32'(in_idx) < TRIG_BOX_ENTRIES);

    fbcv_box_ram #(.DEPTH(BOX_ENTRIES)) u_dead_ram (
        .clk   (clk),
        .we    (dead_we),
        .waddr (DAW'(in_idx)),
        .wdata ({in_y, in_x}),
        .raddr (cnt_reg[DAW-1:0]),
        .rdata (dead_rdata)
    );

    fbcv_box_ram #(.DEPTH(TRIG_BOX_ENTRIES)) u_trig_ram (
        .clk   (clk),
        .we    (trig_we),
        .waddr (TAW'(in_idx)),
        .wdata ({in_y, in_x}),
        .raddr (cnt_reg[TAW-1:0]),
        .rdata (trig_rdata)
    );

    // shared unit
    fbcv_pkg::alu_ctl_t alu_ctl;
    logic signed [15:0] ctr_x, ctr_y;
    logic [14:0]        ctr_r;
    logic               box_hit, circ_hit;

    fbcv_alu u_alu (
        .clk      (clk),
        .ctl      (alu_ctl),
        .pt_x     (px_reg),
        .pt_y     (py_reg),
        .ctr_x    (ctr_x),
        .ctr_y    (ctr_y),
        .radius   (ctr_r),
        .box_hit  (box_hit),
        .circ_hit (circ_hit)
    );

    logic can_issue;

    assign n_cur     = tbl_reg ? n_trig : n_dead;
    assign can_issue = cnt_reg < n_cur;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next  = state_reg;
        tbl_next    = tbl_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        cidx_next   = cidx_reg;
        cstep_next  = cstep_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        reason_next = reason_reg;
        wack_next   = wack_reg;
        alu_ctl.op  = fbcv_pkg::OP_NONE;
        alu_ctl.hw  = tbl_reg ? trig_hw_reg : dead_hw_reg;
        ctr_r       = circ_r_reg[cidx_reg[CIW-1:0]];
        if (state_reg == ST_CIRC)
        begin
            ctr_x = circ_x_reg[cidx_reg[CIW-1:0]];
            ctr_y = circ_y_reg[cidx_reg[CIW-1:0]];
        end
        else
        begin
            ctr_x = tbl_reg ? trig_rdata[15:0] : dead_rdata[15:0];
            ctr_y = tbl_reg ? trig_rdata[31:16] : dead_rdata[31:16];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    px_next     = in_x;
                    py_next     = in_y;
                    reason_next = fbcv_pkg::REASON_NONE;
                    if (in_func == fbcv_pkg::FUNC_TEST)
                    begin
                        state_next = ST_BOX;
                        tbl_next   = 1'b0;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        wack_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                        wack_next  = 1'b1;
                    end
                end
            end
            ST_BOX:
            begin
                pend_next = can_issue;
                if (can_issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg && box_hit)
                begin
                    reason_next = tbl_reg ? fbcv_pkg::REASON_TRIG : fbcv_pkg::REASON_DEAD;
                    state_next  = ST_FIN;
                    pend_next   = 1'b0;
                end
                else if (!pend_reg && !can_issue)
                begin
                    cnt_next = '0;
                    if (!tbl_reg)
                    begin
                        tbl_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CIRC;
                        cidx_next  = '0;
                        cstep_next = 2'd0;
                    end
                end
            end
            ST_CIRC:
            begin
                case (cstep_reg)
                    2'd0:
                    begin
                        if (cidx_reg < n_circ)
                        begin
                            alu_ctl.op = fbcv_pkg::OP_SQ_DX;
                            cstep_next = 2'd1;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    2'd1:
                    begin
                        alu_ctl.op = fbcv_pkg::OP_SQ_DY_ACC;
                        cstep_next = 2'd2;
                    end
                    2'd2:
                    begin
                        alu_ctl.op = fbcv_pkg::OP_SQ_R_ADD;
                        cstep_next = 2'd3;
                    end
                    default:
                    begin
                        cstep_next = 2'd0;
                        if (circ_hit)
                        begin
                            reason_next = fbcv_pkg::REASON_CIRC;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            cidx_next = cidx_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tbl_reg       <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            cidx_reg      <= '0;
            cstep_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tbl_reg       <= tbl_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            cidx_reg      <= cidx_next;
            cstep_reg     <= cstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        reason_reg <= reason_next;
        wack_reg   <= wack_next;
        if (out_load)
        begin
            out_reason_reg <= reason_reg;
            out_wack_reg   <= wack_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reason_reg,
                            (!out_wack_reg) && (out_reason_reg == fbcv_pkg::REASON_NONE)};
    assign m_axis_tuser  = out_wack_reg;

    `FBCV_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FBCV_ASSERT_IMP(a_write_no_reason, m_axis_tvalid && m_axis_tuser[0],
                     m_axis_tdata[2:0] == 3'd0)
    `FBCV_ASSERT_IMP(a_pend_in_box, pend_reg, state_reg == ST_BOX)
    `FBCV_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

// ===== verif/tb_fiducial_box_circle_veto.sv =====
// Self-checking bench for fiducial_box_circle_veto: directed table, box loads, random phases.
// Holds its own predictor of the box and circle veto tables and checks every result item.
// Depends on fbcv_pkg and the fiducial_box_circle_veto RTL.
`default_nettype none
module tb_fiducial_box_circle_veto;

    localparam int BOXES        = 32;
    localparam int CIRCLES      = 4;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 155;
    localparam int TAIL_CYCLES  = 100;
    localparam int LIMIT_CYCLES = 1_000_000;

    // short names for the stimulus table
    localparam logic [1:0] FN_TEST = fbcv_pkg::FUNC_TEST;
    localparam logic [1:0] FN_DEAD = fbcv_pkg::FUNC_DEAD;
    localparam logic [1:0] FN_TRIG = fbcv_pkg::FUNC_TRIG;
    localparam logic [1:0] FN_CIRC = fbcv_pkg::FUNC_CIRC;
    localparam logic [1:0] RS_NONE = fbcv_pkg::REASON_NONE;
    localparam logic [1:0] RS_DEAD = fbcv_pkg::REASON_DEAD;
    localparam logic [1:0] RS_TRIG = fbcv_pkg::REASON_TRIG;
    localparam logic [1:0] RS_CIRC = fbcv_pkg::REASON_CIRC;
    localparam logic [2:0] RG_DHW  = fbcv_pkg::REG_DEAD_HW;
    localparam logic [2:0] RG_THW  = fbcv_pkg::REG_TRIG_HW;
    localparam logic [2:0] RG_DCNT = fbcv_pkg::REG_DEAD_CNT;
    localparam logic [2:0] RG_TCNT = fbcv_pkg::REG_TRIG_CNT;
    localparam logic [2:0] RG_CCNT = fbcv_pkg::REG_CIRC_CNT;

    typedef struct packed {
        logic [1:0]        func;
        logic [4:0]        idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]       r;
    } veto_item_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] reason;
        logic       ack;
    } veto_result_t;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_val;
        logic [1:0]         func;
        logic [4:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        r;
        bit                 known;
        logic               accepted;
        logic [1:0]         reason;
        logic               ack;
    } veto_row_t;

    // known rows carry the verdict typed in; the rest go through the predictor
    localparam veto_row_t DIR_ROWS [31] = '{
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  -518,   0,      0,     1, 0, RS_CIRC, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  2554,   0,      0,     1, 0, RS_CIRC, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  2555,   0,      0,     1, 1, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  -518,   3072,   0,     1, 0, RS_CIRC, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 31, -32768, -32768, 32767, 1, 1, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  32767,  32767,  0,     1, 1, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_DEAD, 0,  1000,   1000,   0,     1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_DEAD, 31, -32768, 32767,  0,     1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_TRIG, 0,  -2000,  -2000,  0,     1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_TRIG, 31, 32767,  -32768, 0,     1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_CIRC, 1,  8000,   8000,   0,     1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_CIRC, 31, 0,      0,      32767, 1, 0, RS_NONE, 1},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  0,      0,      0,     1, 0, RS_CIRC, 0},
        '{ROW_REG,  RG_DHW,  256,   FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_THW,  100,   FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_DCNT, 1,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_TCNT, 1,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_CCNT, 2,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  1256,   744,    0,     1, 0, RS_DEAD, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  1257,   1000,   0,     0, 0, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  -2100,  -1900,  0,     1, 0, RS_TRIG, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  8000,   8000,   0,     1, 0, RS_CIRC, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  8001,   8000,   0,     1, 1, RS_NONE, 0},
        '{ROW_REG,  RG_CCNT, 7,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_DHW,  32767, FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  -32768, -32768, 0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_CCNT, 0,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_DCNT, 0,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_REG,  RG_TCNT, 0,     FN_TEST, 0,  0,      0,      0,     0, 0, RS_NONE, 0},
        '{ROW_ITEM, RG_DHW,  0,     FN_TEST, 0,  -518,   0,      0,     1, 1, RS_NONE, 0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // entry_index[4:0], pos_x[20:5], pos_y[36:21], circle_radius[51:37], zero pad
    logic [55:0] s_axis_tdata  = '0;
    // func[1:0]
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // accepted[0], reject_reason[2:1], zero pad
    logic [7:0]  m_axis_tdata;
    // write_ack[0]
    logic [0:0]  m_axis_tuser;

    // predictor state
    logic signed [15:0] dead_cx [BOXES];
    logic signed [15:0] dead_cy [BOXES];
    logic signed [15:0] trig_cx [BOXES];
    logic signed [15:0] trig_cy [BOXES];
    logic signed [15:0] circ_cx [CIRCLES];
    logic signed [15:0] circ_cy [CIRCLES];
    logic [14:0]        circ_r  [CIRCLES];
    logic [14:0]        dead_hw = '0;
    logic [14:0]        trig_hw = '0;
    logic [5:0]         dead_n  = '0;
    logic [5:0]         trig_n  = '0;
    logic [2:0]         circ_n  = 3'd1;

    veto_result_t pending_verdicts [$];
    veto_result_t oldest_verdict;
    int           mismatches  = 0;
    int unsigned  cycle_count = 0;
    bit           calm        = 1'b0;
    int           stall_left  = 0;

    fiducial_box_circle_veto DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // standard circle in entry 0, others zero
    initial
    begin
        for (int i = 0; i < CIRCLES; i++)
        begin
            circ_cx[i] = '0;
            circ_cy[i] = '0;
            circ_r[i]  = '0;
        end
        circ_cx[0] = 16'(-((fbcv_pkg::CIRC0_X_MILLI * 256 + 500) / 1000));
        circ_r[0]  = 15'(((fbcv_pkg::CIRC0_R_CM << 8) > fbcv_pkg::RAD_MAX) ?
                         fbcv_pkg::RAD_MAX : (fbcv_pkg::CIRC0_R_CM << 8));
    end

    function automatic int active(int n, int depth);
        return (n > depth) ? depth : n;
    endfunction

    function automatic bit in_square(int px, int py, int cx, int cy, int hw);
        return px >= cx - hw && px <= cx + hw && py >= cy - hw && py <= cy + hw;
    endfunction

    function automatic veto_result_t apply_veto_item(veto_item_t it);
        veto_result_t res;
        logic [1:0]   why;
        int           px;
        int           py;
        int           n;
        int           i;
        longint       dx;
        longint       dy;
        longint       rr;
        res = '0;
        why = fbcv_pkg::REASON_NONE;
        px  = int'(it.x);
        py  = int'(it.y);
        if (it.func != fbcv_pkg::FUNC_TEST)
        begin
            case (it.func)
                fbcv_pkg::FUNC_DEAD:
                begin
                    dead_cx[it.idx] = it.x;
                    dead_cy[it.idx] = it.y;
                end
                fbcv_pkg::FUNC_TRIG:
                begin
                    trig_cx[it.idx] = it.x;
                    trig_cy[it.idx] = it.y;
                end
                default:
                begin
                    if (it.idx < CIRCLES)
                    begin
                        circ_cx[it.idx] = it.x;
                        circ_cy[it.idx] = it.y;
                        circ_r[it.idx]  = it.r;
                    end
                end
            endcase
            res.ack = 1'b1;
            return res;
        end
        n = active(int'(dead_n), BOXES);
        for (i = 0; i < n; i++)
            if (why == fbcv_pkg::REASON_NONE &&
                in_square(px, py, int'(dead_cx[i]), int'(dead_cy[i]), int'(dead_hw)))
                why = fbcv_pkg::REASON_DEAD;
        n = active(int'(trig_n), BOXES);
        for (i = 0; i < n; i++)
            if (why == fbcv_pkg::REASON_NONE &&
                in_square(px, py, int'(trig_cx[i]), int'(trig_cy[i]), int'(trig_hw)))
                why = fbcv_pkg::REASON_TRIG;
        n = active(int'(circ_n), CIRCLES);
        for (i = 0; i < n; i++)
        begin
            dx = longint'(px) - longint'(circ_cx[i]);
            dy = longint'(py) - longint'(circ_cy[i]);
            rr = longint'(circ_r[i]);
            if (why == fbcv_pkg::REASON_NONE && dx * dx + dy * dy <= rr * rr)
                why = fbcv_pkg::REASON_CIRC;
        end
        res.accepted = (why == fbcv_pkg::REASON_NONE);
        res.reason   = why;
        return res;
    endfunction

    function automatic int rim_offset(int span);
        case ($urandom_range(0, 5))
            0: return span;
            1: return -span;
            2: return span + 1;
            3: return -span - 1;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // centres cluster round the origin so tests hit them often
    function automatic logic [15:0] spot();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 12000)) - 6000);
    endfunction

    function automatic logic [14:0] pick_half_width();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 15'h7fff;
            2: return 15'($urandom_range(0, 32767));
            default: return 15'($urandom_range(0, 1500));
        endcase
    endfunction

    function automatic veto_item_t aim_point();
        veto_item_t it;
        int         n;
        int         k;
        it.func = fbcv_pkg::FUNC_TEST;
        it.idx  = 5'($urandom_range(0, 31));
        it.r    = 15'($urandom_range(0, 32767));
        it.x    = 16'($urandom);
        it.y    = 16'($urandom);
        case ($urandom_range(0, 3))
            1:
            begin
                n = active(int'(dead_n), BOXES);
                if (n > 0)
                begin
                    k    = int'($urandom_range(0, n - 1));
                    it.x = 16'(int'(dead_cx[k]) + rim_offset(int'(dead_hw)));
                    it.y = 16'(int'(dead_cy[k]) + rim_offset(int'(dead_hw)));
                end
            end
            2:
            begin
                n = active(int'(trig_n), BOXES);
                if (n > 0)
                begin
                    k    = int'($urandom_range(0, n - 1));
                    it.x = 16'(int'(trig_cx[k]) + rim_offset(int'(trig_hw)));
                    it.y = 16'(int'(trig_cy[k]) + rim_offset(int'(trig_hw)));
                end
            end
            3:
            begin
                n = active(int'(circ_n), CIRCLES);
                if (n > 0)
                begin
                    k    = int'($urandom_range(0, n - 1));
                    it.x = 16'(int'(circ_cx[k]) + rim_offset(int'(circ_r[k])));
                    it.y = $urandom_range(0, 1) ? circ_cy[k]
                         : 16'(int'(circ_cy[k]) + rim_offset(int'(circ_r[k])));
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic veto_item_t random_write();
        veto_item_t it;
        case ($urandom_range(0, 2))
            0: it.func = fbcv_pkg::FUNC_DEAD;
            1: it.func = fbcv_pkg::FUNC_TRIG;
            default: it.func = fbcv_pkg::FUNC_CIRC;
        endcase
        it.idx = 5'($urandom_range(0, 31));
        if (it.func == fbcv_pkg::FUNC_CIRC && $urandom_range(0, 3) != 0)
            it.idx = 5'($urandom_range(0, CIRCLES - 1));
        it.x = spot();
        it.y = spot();
        it.r = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                           : 15'($urandom_range(0, 4000));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic offer_item(input veto_item_t it, input bit known, input veto_result_t typed);
        veto_result_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.r, it.y, it.x, it.idx};
        s_axis_tuser  <= it.func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_veto_item(it);
        pending_verdicts.push_back(known ? typed : predicted);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_reg(input logic [2:0] which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (which)
            fbcv_pkg::REG_DEAD_HW:  dead_hw = value[14:0];
            fbcv_pkg::REG_TRIG_HW:  trig_hw = value[14:0];
            fbcv_pkg::REG_DEAD_CNT: dead_n  = value[5:0];
            fbcv_pkg::REG_TRIG_CNT: trig_n  = value[5:0];
            fbcv_pkg::REG_CIRC_CNT: circ_n  = value[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (calm)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= int'($urandom_range(0, 13));
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result item with none pending", int'(m_axis_tdata), 0);
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== oldest_verdict.accepted)
                    report_mismatch("accepted", int'(m_axis_tdata[0]),
                                    int'(oldest_verdict.accepted));
                if (m_axis_tdata[2:1] !== oldest_verdict.reason)
                    report_mismatch("reject_reason", int'(m_axis_tdata[2:1]),
                                    int'(oldest_verdict.reason));
                if (m_axis_tuser[0] !== oldest_verdict.ack)
                    report_mismatch("write_ack", int'(m_axis_tuser[0]),
                                    int'(oldest_verdict.ack));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        veto_item_t   it;
        veto_result_t typed;
        int           k;
        int           phase;
        logic [14:0]  hw_d;
        logic [14:0]  hw_t;
        logic [5:0]   n_d;
        logic [5:0]   n_t;
        logic [2:0]   n_c;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[k])
        begin
            if (DIR_ROWS[k].kind == ROW_REG)
            begin
                settle_block();
                program_reg(DIR_ROWS[k].reg_idx, DIR_ROWS[k].reg_val);
            end
            else
            begin
                it    = '{DIR_ROWS[k].func, DIR_ROWS[k].idx, DIR_ROWS[k].x, DIR_ROWS[k].y,
                          DIR_ROWS[k].r};
                typed = '{DIR_ROWS[k].accepted, DIR_ROWS[k].reason, DIR_ROWS[k].ack};
                offer_item(it, DIR_ROWS[k].known, typed);
            end
        end

        // load every box entry so any count is safe to test against
        for (k = 0; k < 2 * BOXES; k++)
        begin
            it.func = (k < BOXES) ? fbcv_pkg::FUNC_DEAD : fbcv_pkg::FUNC_TRIG;
            it.idx  = 5'(k % BOXES);
            it.x    = spot();
            it.y    = spot();
            it.r    = 15'($urandom_range(0, 32767));
            offer_item(it, 1'b0, '0);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            calm = (phase == PHASES - 1);
            case (phase)
                0:
                begin
                    hw_d = 15'h7fff;
                    hw_t = 15'h7fff;
                    n_d  = 6'h3f;
                    n_t  = 6'h3f;
                    n_c  = 3'h7;
                end
                1:
                begin
                    hw_d = '0;
                    hw_t = '0;
                    n_d  = '0;
                    n_t  = '0;
                    n_c  = '0;
                end
                2:
                begin
                    hw_d = pick_half_width();
                    hw_t = pick_half_width();
                    n_d  = 6'(BOXES);
                    n_t  = 6'(BOXES);
                    n_c  = 3'(CIRCLES);
                end
                default:
                begin
                    hw_d = pick_half_width();
                    hw_t = pick_half_width();
                    n_d  = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 8));
                    n_t  = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 8));
                    n_c  = 3'($urandom_range(0, 7));
                end
            endcase
            program_reg(fbcv_pkg::REG_DEAD_HW, 32'(hw_d));
            program_reg(fbcv_pkg::REG_TRIG_HW, 32'(hw_t));
            program_reg(fbcv_pkg::REG_DEAD_CNT, 32'(n_d));
            program_reg(fbcv_pkg::REG_TRIG_CNT, 32'(n_t));
            program_reg(fbcv_pkg::REG_CIRC_CNT, 32'(n_c));
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                it = ($urandom_range(0, 9) < 7) ? aim_point() : random_write();
                offer_item(it, 1'b0, '0);
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/fbcv_pkg.sv
rtl/fbcv_box_ram.sv
rtl/fbcv_alu.sv
rtl/fiducial_box_circle_veto.sv
verif/tb_fiducial_box_circle_veto.sv
